// ===== sv/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg: shared definitions of the directory entry table
// Operation and status codes, controller states and stream field widths.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int unsigned SlotsPerSectorDef = 21;
  localparam int unsigned SectorCountDef    = 2;
  localparam int unsigned PayloadBitsDef    = 64;

  localparam int unsigned OpW       = 3;
  localparam int unsigned NameLowW  = 64;
  localparam int unsigned NameHighW = 32;
  localparam int unsigned DataW     = 64;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotW     = 6;

  // Input item: op, name_low, name_high, entry_data, padded to whole bytes.
  localparam int unsigned InFieldsW = OpW + NameLowW + NameHighW + DataW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  // Result item: status, slot_index, found_data.
  localparam int unsigned OutFieldsW = StatusW + SlotW + DataW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_FIND   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_UPDATE = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [DataW-1:0] found;
    logic [SlotW-1:0] slot;
    status_e          status;
  } result_t;

endpackage

// ===== sv/det_mem.sv =====
// ----------------------------------------------------------------------------
// det_mem: slot storage of the directory entry table
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module det_mem #(
  parameter  int unsigned Depth = 42,
  parameter  int unsigned Width = 160,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/directory_entry_table.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table: name-searched directory of slots in two sectors
// Clear, insert, find, remove and update over a linear scan of slot storage.
// ----------------------------------------------------------------------------
// A searched operation (insert, find, remove, update) reads the slots in flat
// order from slot 0 and stops at the first hit (a free slot for insert) or
// after the last slot; its result goes through the result register to the
// output register. Clear and unknown codes go straight to the response state.
// One item is worked on at a time; the scan reads one slot per cycle.
// Reset empties every slot at once through the active-mark flip-flops; the
// storage itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module directory_entry_table #(
  parameter int unsigned SLOTS_PER_SECTOR = det_pkg::SlotsPerSectorDef,
  parameter int unsigned SECTOR_COUNT     = det_pkg::SectorCountDef,
  parameter int unsigned PAYLOAD_BITS     = det_pkg::PayloadBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Fields from bit 0 up: op, name_low, name_high, entry_data, zero padding.
  input  logic [det_pkg::InTdataW-1:0] s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0 up: status, slot_index, found_data.
  output logic [det_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  import det_pkg::*;

  // Slots are kept in flat order, slot i of sector s at 2*i+s, which is also
  // the search order, so the scan simply walks the addresses upward.
  localparam int unsigned Total = SLOTS_PER_SECTOR * SECTOR_COUNT;
  localparam int unsigned IdxW  = $clog2(Total);
  localparam int unsigned MemW  = NameLowW + NameHighW + PAYLOAD_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Total - 1);

  // Input field slices.
  logic [OpW-1:0]          in_op;
  logic [NameLowW-1:0]     in_name_lo;
  logic [NameHighW-1:0]    in_name_hi;
  logic [PAYLOAD_BITS-1:0] in_data;

  assign in_op      = s_axis_tdata[OpW-1:0];
  assign in_name_lo = s_axis_tdata[OpW +: NameLowW];
  assign in_name_hi = s_axis_tdata[OpW+NameLowW +: NameHighW];
  assign in_data    = s_axis_tdata[OpW+NameLowW+NameHighW +: PAYLOAD_BITS];

  // Control state.
  state_e             state_q, state_d;
  logic [IdxW-1:0]    rd_k_q, rd_k_d;
  logic [IdxW-1:0]    cmp_k_q;
  logic               cmp_vld_q, cmp_vld_d;
  logic [Total-1:0]   active_q, active_d;
  logic               m_valid_q;

  // Item and result holding registers.
  op_e                     op_q;
  logic [NameLowW-1:0]     name_lo_q;
  logic [NameHighW-1:0]    name_hi_q;
  logic [PAYLOAD_BITS-1:0] data_q;
  result_t                 res_q, res_d;
  result_t                 out_q;

  // Storage port.
  logic                    mem_we;
  logic [MemW-1:0]         mem_wdata;
  logic [MemW-1:0]         mem_rdata;
  logic [NameLowW-1:0]     rd_name_lo;
  logic [NameHighW-1:0]    rd_name_hi;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic in_xfer;
  logic out_load;
  logic slot_act;
  logic name_eq;
  logic hit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  det_mem #(
    .Depth (Total),
    .Width (MemW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cmp_k_q),
    .wdata_i (mem_wdata),
    .raddr_i (rd_k_q),
    .rdata_o (mem_rdata)
  );

  // Storage word layout, high bits first: name_low, name_high, payload.
  assign rd_payload = mem_rdata[PAYLOAD_BITS-1:0];
  assign rd_name_hi = mem_rdata[PAYLOAD_BITS +: NameHighW];
  assign rd_name_lo = mem_rdata[PAYLOAD_BITS+NameHighW +: NameLowW];

  // The read data that arrives now belongs to slot cmp_k_q. The active mark
  // is taken from the flip-flops directly, so it is always current.
  assign slot_act = active_q[cmp_k_q];
  assign name_eq  = (rd_name_lo == name_lo_q) && (rd_name_hi == name_hi_q);

  always_comb begin
    case (op_q)
      OP_INSERT: hit = !slot_act;
      OP_FIND,
      OP_REMOVE,
      OP_UPDATE: hit = slot_act && name_eq;
      default:   hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    rd_k_d    = rd_k_q;
    cmp_vld_d = 1'b0;
    active_d  = active_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wdata = {rd_name_lo, rd_name_hi, data_q};
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          rd_k_d = '0;
          case (op_e'(in_op))
            OP_CLEAR: begin
              active_d = '0;
              res_d    = '{found: '0, slot: '0, status: ST_OK};
              state_d  = S_RESP;
            end
            OP_INSERT, OP_FIND, OP_REMOVE, OP_UPDATE: begin
              state_d = S_SCAN;
            end
            default: begin
              res_d   = '{found: '0, slot: '0, status: ST_OK};
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read; the address saturates at the last slot, whose
        // compare ends the scan before a repeated read is ever looked at.
        cmp_vld_d = 1'b1;
        if (rd_k_q != LastIdx) begin
          rd_k_d = rd_k_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (hit) begin
            res_d     = '{found: '0, slot: SlotW'(cmp_k_q), status: ST_OK};
            cmp_vld_d = 1'b0;
            state_d   = S_RESP;
            case (op_q)
              OP_INSERT: begin
                active_d[cmp_k_q] = 1'b1;
                mem_we            = 1'b1;
                mem_wdata         = {name_lo_q, name_hi_q, data_q};
              end
              OP_FIND: begin
                res_d.found = DataW'(rd_payload);
              end
              OP_REMOVE: begin
                active_d[cmp_k_q] = 1'b0;
              end
              OP_UPDATE: begin
                mem_we = 1'b1;
              end
              default: begin
              end
            endcase
          end else if (cmp_k_q == LastIdx) begin
            res_d.found  = '0;
            res_d.slot   = '0;
            res_d.status = (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
            cmp_vld_d    = 1'b0;
            state_d      = S_RESP;
          end
        end
      end

      S_RESP: begin
        // Hand the result to the output register as soon as it is free.
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_k_q    <= '0;
      cmp_vld_q <= 1'b0;
      active_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_k_q    <= rd_k_d;
      cmp_vld_q <= cmp_vld_d;
      active_q  <= active_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_k_q <= rd_k_q;
    res_q   <= res_d;
    if (in_xfer) begin
      op_q      <= op_e'(in_op);
      name_lo_q <= in_name_lo;
      name_hi_q <= in_name_hi;
      data_q    <= in_data;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutTdataW'({out_q.found, out_q.slot, out_q.status});

endmodule
